### rtl/sha512_pkg.sv
// Types, constants and functions shared by the SHA-384/512 hash unit.
package sha512_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned ROUNDS = 80;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam logic [32:0] BYTE_CAP = 33'h1_0000_0000;
    localparam logic [3:0] FULL_BYTES = 4'd8;
    localparam logic [63:0] PAD_MARK = 64'h8000_0000_0000_0000;

    localparam logic MODE_384 = 1'b0;
    localparam logic MODE_512 = 1'b1;

    typedef logic [7:0][63:0] word8_t;
    typedef logic [BLOCK_WORDS-1:0][63:0] window_t;

    typedef struct packed {
        logic [63:0] message_word;
        logic [3:0]  bytes_valid;
        logic        last_word;
    } in_item_t;

    typedef struct packed {
        logic [63:0] hash_word;
        logic        digest_last;
        logic        too_long;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT,
        ST_ERR
    } state_t;

    typedef enum logic [2:0] {
        PS_NONE,
        PS_MARK,
        PS_ZERO,
        PS_LEN,
        PS_DONE
    } pad_t;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] small_s0(input logic [63:0] x);
        small_s0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic logic [63:0] small_s1(input logic [63:0] x);
        small_s1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

    // Keep the valid bytes, place the marker byte right after them, zero the rest.
    function automatic logic [63:0] pad_word(input logic [63:0] w, input logic [3:0] nb);
        logic [63:0] res;
        res = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < nb)
                res[63-8*i -: 8] = w[63-8*i -: 8];
            else if (4'(i) == nb)
                res[63-8*i -: 8] = 8'h80;
        end
        return res;
    endfunction

    function automatic word8_t iv_words(input logic mode);
        word8_t v;
        if (mode == MODE_384)
        begin
            v[0] = 64'hcbbb9d5dc1059ed8; v[1] = 64'h629a292a367cd507;
            v[2] = 64'h9159015a3070dd17; v[3] = 64'h152fecd8f70e5939;
            v[4] = 64'h67332667ffc00b31; v[5] = 64'h8eb44a8768581511;
            v[6] = 64'hdb0c2e0d64f98fa7; v[7] = 64'h47b5481dbefa4fa4;
        end
        else
        begin
            v[0] = 64'h6a09e667f3bcc908; v[1] = 64'hbb67ae8584caa73b;
            v[2] = 64'h3c6ef372fe94f82b; v[3] = 64'ha54ff53a5f1d36f1;
            v[4] = 64'h510e527fade682d1; v[5] = 64'h9b05688c2b3e6c1f;
            v[6] = 64'h1f83d9abfb41bd6b; v[7] = 64'h5be0cd19137e2179;
        end
        return v;
    endfunction

    function automatic logic [63:0] round_k(input logic [6:0] t);
        logic [63:0] k;
        case (t)
            7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

### rtl/sha512_round.sv
// One SHA-512 round plus one message-schedule expansion step.
module sha512_round (
    input  sha512_pkg::word8_t   vars,
    input  sha512_pkg::window_t  win,
    input  logic [63:0]          k,
    output sha512_pkg::word8_t   vars_out,
    output logic [63:0]          sched
);
    import sha512_pkg::*;

    logic [63:0] big_s1, big_s0, ch, maj, t1, t2;

    always_comb
    begin
        big_s1 = rotr(vars[4], 14) ^ rotr(vars[4], 18) ^ rotr(vars[4], 41);
        big_s0 = rotr(vars[0], 28) ^ rotr(vars[0], 34) ^ rotr(vars[0], 39);
        ch     = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
        maj    = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
        t1     = vars[7] + big_s1 + ch + k + win[0];
        t2     = big_s0 + maj;
        vars_out[0] = t1 + t2;
        vars_out[1] = vars[0];
        vars_out[2] = vars[1];
        vars_out[3] = vars[2];
        vars_out[4] = vars[3] + t1;
        vars_out[5] = vars[4];
        vars_out[6] = vars[5];
        vars_out[7] = vars[6];
        sched = win[0] + small_s0(win[1]) + win[9] + small_s1(win[14]);
    end

endmodule

### rtl/sha384_512_hash_unit.sv
// Top level of the SHA-384/512 hash unit: buffering, padding, sequencing, output.
//
// Input channel (in_valid/in_stall/in_data) takes big-endian 64-bit message words;
// the word with last_word set carries 0 to 8 left-aligned valid bytes. Output
// channel (out_valid/out_stall/out_data) returns eight digest words, word 0 first,
// digest_last on the eighth; a message of 2^32 bytes or more instead returns a
// single result with too_long and digest_last set. The APB port holds hash_mode
// (0 = SHA-384, 1 = SHA-512 initial values) at address 0.
// A word that does not complete a block leaves the unit idle. A word that completes
// a block starts 80 rounds through the shared round unit, one per cycle, then
// a fold of the working variables into the chaining words.
// After the last word, padding words follow one per cycle, pausing for the rounds
// of each block they fill (one or two more blocks); the digest words then leave one
// per cycle while out_stall is low. in_stall is high whenever the unit is not idle.
// Reset selects SHA-512 and clears all counters. A stalled output holds its word
// in the output register, and the digest sequencer waits on it.
module sha384_512_hash_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sha512_pkg::in_item_t  in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sha512_pkg::out_item_t out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import sha512_pkg::*;

    state_t      state_reg, state_next;
    pad_t        pad_reg, pad_next;
    logic [3:0]  fill_reg, fill_next;
    logic [6:0]  round_reg, round_next;
    logic [32:0] bt_reg, bt_next;
    logic        mode_reg, mode_next;
    logic [2:0]  idx_reg, idx_next;
    word8_t      chain_reg, chain_next;
    word8_t      work_reg, work_next;
    window_t     win_reg, win_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg, out_next;

    word8_t      round_vars;
    logic [63:0] sched;
    logic        in_acc, cfg_wr, slot_free, push_en, reload, load_work, round_en;
    logic [63:0] push_data;
    logic [3:0]  nb;
    logic [33:0] bt_sum;
    logic [32:0] bt_sat;

    sha512_round u_round (
        .vars     (work_reg),
        .win      (win_reg),
        .k        (round_k(round_reg)),
        .vars_out (round_vars),
        .sched    (sched)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_wr    = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign slot_free = !out_valid_reg || !out_stall;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == 1'b0) ? {31'd0, mode_reg} : 32'd0;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign nb     = (!in_data.last_word || in_data.bytes_valid > FULL_BYTES) ?
                    FULL_BYTES : in_data.bytes_valid;
    assign bt_sum = {1'b0, bt_reg} + {30'd0, nb};
    assign bt_sat = (bt_sum > {1'b0, BYTE_CAP}) ? BYTE_CAP : bt_sum[32:0];

    always_comb
    begin
        state_next     = state_reg;
        pad_next       = pad_reg;
        fill_next      = fill_reg;
        round_next     = round_reg;
        bt_next        = bt_reg;
        mode_next      = mode_reg;
        idx_next       = idx_reg;
        chain_next     = chain_reg;
        work_next      = work_reg;
        win_next       = win_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        push_en        = 1'b0;
        push_data      = '0;
        reload         = 1'b0;
        load_work      = 1'b0;
        round_en       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    bt_next = bt_sat;
                    if (!in_data.last_word)
                    begin
                        push_en   = 1'b1;
                        push_data = in_data.message_word;
                    end
                    else if (bt_sat[32])
                    begin
                        reload     = 1'b1;
                        state_next = ST_ERR;
                    end
                    else
                    begin
                        push_en    = 1'b1;
                        push_data  = (nb == FULL_BYTES) ? in_data.message_word :
                                     pad_word(in_data.message_word, nb);
                        pad_next   = (nb == FULL_BYTES) ? PS_MARK : PS_ZERO;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                push_en = 1'b1;
                case (pad_reg)
                    PS_MARK:
                    begin
                        push_data = PAD_MARK;
                        pad_next  = PS_ZERO;
                    end
                    PS_ZERO:
                    begin
                        push_data = '0;
                        if (fill_reg == 4'd14)
                            pad_next = PS_LEN;
                    end
                    PS_LEN:
                    begin
                        push_data = {28'd0, bt_reg, 3'd0};
                        pad_next  = PS_DONE;
                    end
                    default:
                    begin
                        push_en = 1'b0;
                    end
                endcase
            end
            ST_ROUND:
            begin
                round_en = 1'b1;
                if (round_reg == 7'(ROUNDS - 1))
                begin
                    round_next = '0;
                    state_next = ST_ADD;
                end
                else
                begin
                    round_next = round_reg + 7'd1;
                end
            end
            ST_ADD:
            begin
                for (int i = 0; i < 8; i++)
                    chain_next[i] = chain_reg[i] + work_reg[i];
                if (pad_reg == PS_NONE)
                    state_next = ST_IDLE;
                else if (pad_reg == PS_DONE)
                    state_next = ST_EMIT;
                else
                    state_next = ST_PAD;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.hash_word    = chain_reg[idx_reg];
                    out_next.digest_last  = (idx_reg == 3'd7);
                    out_next.too_long     = 1'b0;
                    idx_next              = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        reload     = 1'b1;
                        pad_next   = PS_NONE;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR:
            begin
                if (slot_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.hash_word   = '0;
                    out_next.digest_last = 1'b1;
                    out_next.too_long    = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Shift a word into the block window; a full window starts the rounds.
        if (push_en)
        begin
            win_next  = {push_data, win_reg[BLOCK_WORDS-1:1]};
            fill_next = fill_reg + 4'd1;
            if (fill_reg == 4'(BLOCK_WORDS - 1))
            begin
                load_work  = 1'b1;
                state_next = ST_ROUND;
            end
        end
        if (load_work)
            work_next = chain_reg;
        if (round_en)
        begin
            work_next = round_vars;
            win_next  = {sched, win_reg[BLOCK_WORDS-1:1]};
        end

        if (reload)
        begin
            chain_next = iv_words(mode_reg);
            bt_next    = '0;
            fill_next  = '0;
        end

        if (cfg_wr)
        begin
            mode_next = pwdata[0];
            if (bt_reg == '0 && fill_reg == '0)
                chain_next = iv_words(pwdata[0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pad_reg       <= PS_NONE;
            fill_reg      <= '0;
            round_reg     <= '0;
            bt_reg        <= '0;
            mode_reg      <= MODE_512;
            idx_reg       <= '0;
            chain_reg     <= iv_words(MODE_512);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pad_reg       <= pad_next;
            fill_reg      <= fill_next;
            round_reg     <= round_next;
            bt_reg        <= bt_next;
            mode_reg      <= mode_next;
            idx_reg       <= idx_next;
            chain_reg     <= chain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        win_reg  <= win_next;
        out_reg  <= out_next;
    end

    a_round_on_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND |-> fill_reg == 4'd0)
        else $error("rounds running on a partial block");

    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND && round_reg == 7'(ROUNDS - 1) |=> state_reg == ST_ADD)
        else $error("last round not followed by chaining add");

    a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.too_long |-> out_reg.digest_last && out_reg.hash_word == '0)
        else $error("malformed length error result");

endmodule

### bench/tb_sha384_512_hash_unit.sv
// Self-checking bench for the SHA-384/512 hash unit: directed table, then random messages.
module tb_sha384_512_hash_unit;
    import sha512_pkg::*;

    localparam logic [63:0] RC_TAB [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

    localparam logic [63:0] IV384 [8] = '{
        64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
        64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};
    localparam logic [63:0] IV512 [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
    // Digest of the empty message with SHA-512 initial values.
    localparam logic [63:0] EMPTY512 [8] = '{
        64'hcf83e1357eefb8bd, 64'hf1542850d66d8007, 64'hd620e4050b5715dc, 64'h83f4a921d36ce9ce,
        64'h47d0d13c5d85f2b0, 64'hff8318d2877eec2f, 64'h63b931bd47417a81, 64'ha538327af927da3e};
    localparam logic [32:0] LEN_CAP = 33'h1_0000_0000;

    typedef struct {
        logic [63:0] word;
        logic [3:0]  nb;
        logic        last;
        bit          empty_digest;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // digest model state
    logic [63:0] chain_h [8];
    logic [63:0] blk_w [16];
    logic [32:0] msg_bytes;
    int          fill_pos;
    logic        mode_sel;

    out_item_t   digest_q [$];
    out_item_t   new_res [8];
    int          new_cnt;
    int          errors;
    bit          quiet;

    sha384_512_hash_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [63:0] ror(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic load_iv();
        for (int i = 0; i < 8; i++)
            chain_h[i] = (mode_sel == MODE_384) ? IV384[i] : IV512[i];
        msg_bytes = '0;
        fill_pos = 0;
    endtask

    task automatic compress_block();
        logic [63:0] w [80];
        logic [63:0] v [8];
        logic [63:0] t1;
        logic [63:0] t2;
        for (int t = 0; t < 16; t++)
            w[t] = blk_w[t];
        for (int t = 16; t < 80; t++)
            w[t] = w[t-16] + (ror(w[t-15], 1) ^ ror(w[t-15], 8) ^ (w[t-15] >> 7))
                 + w[t-7] + (ror(w[t-2], 19) ^ ror(w[t-2], 61) ^ (w[t-2] >> 6));
        for (int i = 0; i < 8; i++)
            v[i] = chain_h[i];
        for (int t = 0; t < 80; t++)
        begin
            t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RC_TAB[t] + w[t];
            t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int i = 7; i > 0; i--)
                v[i] = v[i-1];
            v[0] = t1 + t2;
            v[4] = v[4] + t1;
        end
        for (int i = 0; i < 8; i++)
            chain_h[i] = chain_h[i] + v[i];
    endtask

    task automatic absorb(input logic [63:0] w);
        blk_w[fill_pos] = w;
        fill_pos = (fill_pos + 1) % 16;
        if (fill_pos == 0)
            compress_block();
    endtask

    // Fold one accepted word into the model; results land in new_res.
    task automatic predict_digest(input in_item_t it);
        int n;
        logic [63:0] keep;
        n = (!it.last_word || it.bytes_valid > 8) ? 8 : int'(it.bytes_valid);
        msg_bytes = msg_bytes + 33'(n);
        if (msg_bytes > LEN_CAP)
            msg_bytes = LEN_CAP;
        new_cnt = 0;
        if (!it.last_word)
        begin
            absorb(it.message_word);
            return;
        end
        if (msg_bytes > 33'hFFFF_FFFF)
        begin
            new_res[0] = '{hash_word: '0, digest_last: 1'b1, too_long: 1'b1};
            new_cnt = 1;
            load_iv();
            return;
        end
        if (n == 8)
        begin
            absorb(it.message_word);
            absorb(PAD_MARK);
        end
        else
        begin
            keep = (n == 0) ? '0 : (~64'h0 << (64 - 8 * n));
            absorb((it.message_word & keep) | (64'h80 << (56 - 8 * n)));
        end
        if (fill_pos == 15)
            absorb('0);
        while (fill_pos != 14)
            absorb('0);
        absorb('0);
        absorb({28'h0, msg_bytes, 3'b000});
        for (int k = 0; k < 8; k++)
            new_res[k] = '{hash_word: chain_h[k], digest_last: (k == 7), too_long: 1'b0};
        new_cnt = 8;
        load_iv();
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s got %h want %h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (digest_q.size() == 0)
                report_mismatch("unexpected digest transfer", out_data.hash_word, '0);
            else
            begin
                if (out_data.hash_word !== digest_q[0].hash_word)
                    report_mismatch("hash_word", out_data.hash_word, digest_q[0].hash_word);
                if (out_data.digest_last !== digest_q[0].digest_last)
                    report_mismatch("digest_last", out_data.digest_last,
                                    digest_q[0].digest_last);
                if (out_data.too_long !== digest_q[0].too_long)
                    report_mismatch("too_long", out_data.too_long, digest_q[0].too_long);
                void'(digest_q.pop_front());
            end
        end
    end

    // Receiver back-pressure.
    always @(negedge clk)
        out_stall <= !quiet && ($urandom_range(99) < 21);

    task automatic send_word(input in_item_t it, input bit typed_empty);
        while (!quiet && $urandom_range(99) < 21)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (in_stall);
        predict_digest(it);
        for (int k = 0; k < new_cnt; k++)
        begin
            if (typed_empty)
                digest_q.push_back('{hash_word: EMPTY512[k], digest_last: (k == 7),
                                     too_long: 1'b0});
            else
                digest_q.push_back(new_res[k]);
        end
        @(negedge clk);
    endtask

    // Drain, let any block in flight finish, then write hash_mode.
    task automatic write_mode(input logic [31:0] value);
        in_valid <= 1'b0;
        wait (digest_q.size() == 0);
        repeat (120) @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        mode_sel = value[0];
        if (msg_bytes == 0 && fill_pos == 0)
            load_iv();
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        stim_row_t rows [$];
        in_item_t  it;
        int        len;
        int        sent;
        errors = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mode_sel = MODE_512;
        for (int i = 0; i < 16; i++)
            blk_w[i] = '0;
        load_iv();

        // empty message right after reset, then oversized and full last words
        rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1, 1'b1});
        rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 1'b0});
        rows.push_back('{64'h0000_0000_0000_0000, 4'd8, 1'b1, 1'b0});
        rows.push_back('{64'h6162_63FF_FFFF_FFFF, 4'd3, 1'b1, 1'b0});
        rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1, 1'b0});
        rows.push_back('{64'h0123_4567_89AB_CDEF, 4'd7, 1'b1, 1'b0});
        // 112 bytes: exact fit forces an extra padding block; bytes_valid on inner words is ignored
        for (int i = 0; i < 13; i++)
            rows.push_back('{64'hA5A5_0000_0000_0000 + i, 4'(i), 1'b0, 1'b0});
        rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 1'b1, 1'b0});

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            it = '{message_word: rows[i].word, bytes_valid: rows[i].nb,
                   last_word: rows[i].last};
            send_word(it, rows[i].empty_digest);
            // SHA-384 empty message and back
            if (i == 0)
            begin
                write_mode(32'h0);
                send_word('{message_word: '0, bytes_valid: 4'd0, last_word: 1'b1}, 1'b0);
                write_mode(32'hFFFF_FFFF);
            end
        end

        sent = 0;
        while (sent < 240)
        begin
            if ($urandom_range(3) == 0)
                write_mode($urandom);
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 18);
            for (int j = 0; j < len; j++)
            begin
                quiet = (sent >= 100 && sent < 150);
                it.message_word = rand_word();
                it.bytes_valid = 4'($urandom_range(15));
                it.last_word = (j == len - 1);
                send_word(it, 1'b0);
                sent++;
                // mode change in the middle of a message applies to the next one
                if (j == 2 && len > 4 && $urandom_range(7) == 0)
                    write_mode($urandom);
            end
        end
        quiet = 1'b0;
        in_valid <= 1'b0;
        wait (digest_q.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
